### rtl/sobb_pkg.sv
`default_nettype none
package sobb_pkg;

	localparam int MW  = 20;	// rotation matrix entry, scale 2^14
	localparam int RLW = 33;	// world offset sphere minus box
	localparam int LW  = 42;	// box-space position, scale 2^1
	localparam int FW  = 43;	// face distance
	localparam int QTW = 15;	// normal quotient

	localparam logic [63:0] EPS_SQ = 64'd171799;

	typedef struct packed {
		logic signed [31:0] sphere_x;
		logic signed [31:0] sphere_y;
		logic signed [31:0] sphere_z;
		logic [30:0]        sphere_radius;
		logic signed [31:0] box_x;
		logic signed [31:0] box_y;
		logic signed [31:0] box_z;
		logic [30:0]        box_size_x;
		logic [30:0]        box_size_y;
		logic [30:0]        box_size_z;
		logic [63:0]        box_quat;
	} sobb_req_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] pen_depth;
	} sobb_rsp_t;

	// mat[row][col], each entry two's complement
	typedef logic [2:0][2:0][MW-1:0] sobb_mat_t;

	// Sideband that follows a request through the square root and divider.
	typedef struct packed {
		sobb_mat_t       mat;
		logic [31:0]     r2x;
		logic [2:0][31:0] aoff;
		logic [2:0]      neg;
		logic            in_box;
		logic            miss;
		sobb_rsp_t       irsp;
	} sobb_side_t;

	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			return 32'h8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic [15:0] clamp_nrm(input logic signed [23:0] v);
		if (v > 24'sd16384) begin
			return 16'd16384;
		end else if (v < -24'sd16384) begin
			return 16'hC000;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage
`default_nettype wire

### rtl/sobb_front.sv
`default_nettype none
module sobb_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  sobb_pkg::sobb_req_t   req,
	output logic                  vld,
	output logic [63:0]           d2,
	output sobb_pkg::sobb_side_t  side
);
	import sobb_pkg::*;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	function automatic logic [MW-1:0] rnd14(input logic signed [34:0] e);
		logic signed [34:0] t;
		t = (e + 35'sd8192) >>> 14;
		return t[MW-1:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// stage 1: offsets and quaternion products
	logic signed [RLW-1:0] rel_s1 [3];
	logic [30:0]           half_s1 [3];
	logic [31:0]           r2x_s1;
	logic signed [31:0]    pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	logic signed [31:0]    pxw_s1, pyw_s1, pzw_s1;
	logic signed [15:0]    qx, qy, qz, qw;

	assign qx = $signed(req.box_quat[63:48]);
	assign qy = $signed(req.box_quat[47:32]);
	assign qz = $signed(req.box_quat[31:16]);
	assign qw = $signed(req.box_quat[15:0]);

	always_ff @(posedge clk) begin
		rel_s1[0] <= $signed({req.sphere_x[31], req.sphere_x}) - $signed({req.box_x[31], req.box_x});
		rel_s1[1] <= $signed({req.sphere_y[31], req.sphere_y}) - $signed({req.box_y[31], req.box_y});
		rel_s1[2] <= $signed({req.sphere_z[31], req.sphere_z}) - $signed({req.box_z[31], req.box_z});
		half_s1[0] <= req.box_size_x;
		half_s1[1] <= req.box_size_y;
		half_s1[2] <= req.box_size_z;
		r2x_s1 <= {req.sphere_radius, 1'b0};
		pxx_s1 <= qx * qx;
		pyy_s1 <= qy * qy;
		pzz_s1 <= qz * qz;
		pxy_s1 <= qx * qy;
		pxz_s1 <= qx * qz;
		pyz_s1 <= qy * qz;
		pxw_s1 <= qx * qw;
		pyw_s1 <= qy * qw;
		pzw_s1 <= qz * qw;
	end

	// stage 2: rotation matrix
	sobb_mat_t             mat_s2;
	logic signed [RLW-1:0] rel_s2 [3];
	logic [30:0]           half_s2 [3];
	logic [31:0]           r2x_s2;
	localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

	always_ff @(posedge clk) begin
		mat_s2[0][0] <= rnd14(ONE_Q28 - ((35'(pyy_s1) + 35'(pzz_s1)) <<< 1));
		mat_s2[1][1] <= rnd14(ONE_Q28 - ((35'(pxx_s1) + 35'(pzz_s1)) <<< 1));
		mat_s2[2][2] <= rnd14(ONE_Q28 - ((35'(pxx_s1) + 35'(pyy_s1)) <<< 1));
		mat_s2[0][1] <= rnd14((35'(pxy_s1) - 35'(pzw_s1)) <<< 1);
		mat_s2[0][2] <= rnd14((35'(pxz_s1) + 35'(pyw_s1)) <<< 1);
		mat_s2[1][0] <= rnd14((35'(pxy_s1) + 35'(pzw_s1)) <<< 1);
		mat_s2[1][2] <= rnd14((35'(pyz_s1) - 35'(pxw_s1)) <<< 1);
		mat_s2[2][0] <= rnd14((35'(pxz_s1) - 35'(pyw_s1)) <<< 1);
		mat_s2[2][1] <= rnd14((35'(pyz_s1) + 35'(pxw_s1)) <<< 1);
		rel_s2  <= rel_s1;
		half_s2 <= half_s1;
		r2x_s2  <= r2x_s1;
	end

	// stage 3: transpose rotation products, prod_s3[i][k] = M[k][i] * rel[k]
	logic signed [52:0] prod_s3 [3][3];
	sobb_mat_t          mat_s3;
	logic [30:0]        half_s3 [3];
	logic [31:0]        r2x_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				prod_s3[i][k] <= $signed(mat_s2[k][i]) * rel_s2[k];
			end
		end
		mat_s3  <= mat_s2;
		half_s3 <= half_s2;
		r2x_s3  <= r2x_s2;
	end

	// stage 4: box-space position
	logic signed [LW-1:0] loc_s4 [3];
	sobb_mat_t            mat_s4;
	logic [30:0]          half_s4 [3];
	logic [31:0]          r2x_s4;
	logic signed [53:0]   lsum [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsum[i] = ((54'(prod_s3[i][0]) + 54'(prod_s3[i][1]) + 54'(prod_s3[i][2])
				+ 54'sd4096) >>> 13);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			loc_s4[i] <= lsum[i][LW-1:0];
		end
		mat_s4  <= mat_s3;
		half_s4 <= half_s3;
		r2x_s4  <= r2x_s3;
	end

	// stage 5: clamp offsets and face distances
	logic [31:0]          aoff_s5 [3];
	logic [2:0]           neg_s5;
	logic                 sat_s5;
	logic signed [FW-1:0] fd_s5 [6];
	sobb_mat_t            mat_s5;
	logic [31:0]          r2x_s5;
	logic signed [LW-1:0] off [3];
	logic signed [LW-1:0] aoff [3];
	logic signed [LW-1:0] h42 [3];
	logic signed [FW-1:0] h43 [3];
	logic signed [FW-1:0] l43 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			h42[i] = $signed({11'b0, half_s4[i]});
			h43[i] = $signed({12'b0, half_s4[i]});
			l43[i] = {loc_s4[i][LW-1], loc_s4[i]};
			if (loc_s4[i] > h42[i]) begin
				off[i] = loc_s4[i] - h42[i];
			end else if (loc_s4[i] < -h42[i]) begin
				off[i] = loc_s4[i] + h42[i];
			end else begin
				off[i] = '0;
			end
			aoff[i] = off[i][LW-1] ? -off[i] : off[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			aoff_s5[i]     <= aoff[i][31:0];
			neg_s5[i]      <= off[i][LW-1];
			fd_s5[2*i]     <= h43[i] - l43[i];
			fd_s5[2*i + 1] <= l43[i] + h43[i];
		end
		sat_s5 <= (|aoff[0][LW-1:32]) | (|aoff[1][LW-1:32]) | (|aoff[2][LW-1:32]);
		mat_s5 <= mat_s4;
		r2x_s5 <= r2x_s4;
	end

	// stage 6: squares and first round of the face search
	logic [63:0]          sq_s6 [3];
	logic [63:0]          rsq_s6;
	logic                 sat_s6;
	logic signed [FW-1:0] m01_s6, m23_s6, m45_s6;
	logic [2:0]           f01_s6, f23_s6, f45_s6;
	logic [31:0]          aoff_s6 [3];
	logic [2:0]           neg_s6;
	sobb_mat_t            mat_s6;
	logic [31:0]          r2x_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= aoff_s5[i] * aoff_s5[i];
		end
		rsq_s6 <= r2x_s5 * r2x_s5;
		// Ties keep the earlier face.
		if (fd_s5[1] < fd_s5[0]) begin
			m01_s6 <= fd_s5[1];
			f01_s6 <= FACE_NX;
		end else begin
			m01_s6 <= fd_s5[0];
			f01_s6 <= FACE_PX;
		end
		if (fd_s5[3] < fd_s5[2]) begin
			m23_s6 <= fd_s5[3];
			f23_s6 <= FACE_NY;
		end else begin
			m23_s6 <= fd_s5[2];
			f23_s6 <= FACE_PY;
		end
		if (fd_s5[5] < fd_s5[4]) begin
			m45_s6 <= fd_s5[5];
			f45_s6 <= FACE_NZ;
		end else begin
			m45_s6 <= fd_s5[4];
			f45_s6 <= FACE_PZ;
		end
		sat_s6  <= sat_s5;
		aoff_s6 <= aoff_s5;
		neg_s6  <= neg_s5;
		mat_s6  <= mat_s5;
		r2x_s6  <= r2x_s5;
	end

	// stage 7: squared distance, second round of the face search
	logic [63:0]          d2_s7, rsq_s7;
	logic signed [FW-1:0] m03_s7, m45_s7;
	logic [2:0]           f03_s7, f45_s7;
	logic [31:0]          aoff_s7 [3];
	logic [2:0]           neg_s7;
	sobb_mat_t            mat_s7;
	logic [31:0]          r2x_s7;
	logic [65:0]          dsum;

	assign dsum = 66'(sq_s6[0]) + 66'(sq_s6[1]) + 66'(sq_s6[2]);

	always_ff @(posedge clk) begin
		d2_s7 <= (sat_s6 || (|dsum[65:64])) ? '1 : dsum[63:0];
		if (m23_s6 < m01_s6) begin
			m03_s7 <= m23_s6;
			f03_s7 <= f23_s6;
		end else begin
			m03_s7 <= m01_s6;
			f03_s7 <= f01_s6;
		end
		m45_s7  <= m45_s6;
		f45_s7  <= f45_s6;
		rsq_s7  <= rsq_s6;
		aoff_s7 <= aoff_s6;
		neg_s7  <= neg_s6;
		mat_s7  <= mat_s6;
		r2x_s7  <= r2x_s6;
	end

	// stage 8: classify, finish the face search
	logic [63:0]          d2_s8;
	logic                 inside_s8, miss_s8;
	logic signed [FW-1:0] best_s8;
	logic [2:0]           face_s8;
	logic [31:0]          aoff_s8 [3];
	logic [2:0]           neg_s8;
	sobb_mat_t            mat_s8;
	logic [31:0]          r2x_s8;

	always_ff @(posedge clk) begin
		inside_s8 <= (d2_s7 <= EPS_SQ);
		miss_s8   <= (d2_s7 > EPS_SQ) && (d2_s7 > rsq_s7);
		if (m45_s7 < m03_s7) begin
			best_s8 <= m45_s7;
			face_s8 <= f45_s7;
		end else begin
			best_s8 <= m03_s7;
			face_s8 <= f03_s7;
		end
		d2_s8   <= d2_s7;
		aoff_s8 <= aoff_s7;
		neg_s8  <= neg_s7;
		mat_s8  <= mat_s7;
		r2x_s8  <= r2x_s7;
	end

	// stage 9: contact for a center inside the box
	sobb_side_t          side_s9;
	logic [63:0]         d2_s9;
	logic [1:0]          col;
	logic signed [23:0]  fn [3];
	logic signed [47:0]  idep;

	always_comb begin
		col = face_s8[2:1];
		for (int r = 0; r < 3; r++) begin
			fn[r] = 24'($signed(mat_s8[r][col]));
			if (face_s8[0]) begin
				fn[r] = -fn[r];
			end
		end
		idep = (48'(best_s8) + $signed({16'b0, r2x_s8}) + 48'sd1) >>> 1;
	end

	always_ff @(posedge clk) begin
		side_s9.mat    <= mat_s8;
		side_s9.r2x    <= r2x_s8;
		for (int i = 0; i < 3; i++) begin
			side_s9.aoff[i] <= aoff_s8[i];
		end
		side_s9.neg    <= neg_s8;
		side_s9.in_box <= inside_s8;
		side_s9.miss   <= miss_s8;
		side_s9.irsp.hit       <= 1'b1;
		side_s9.irsp.normal_x  <= clamp_nrm(fn[0]);
		side_s9.irsp.normal_y  <= clamp_nrm(fn[1]);
		side_s9.irsp.normal_z  <= clamp_nrm(fn[2]);
		side_s9.irsp.pen_depth <= sat32(idep);
		d2_s9 <= d2_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{start, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	assign vld  = v_s9;
	assign d2   = d2_s9;
	assign side = side_s9;

	a_inside_not_miss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> !(side_s9.in_box && side_s9.miss))
		else $error("inside and miss both set");
	a_sat_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && (d2_s9 == '1) |-> side_s9.miss)
		else $error("saturated distance not a miss");
	a_inside_eps: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && side_s9.in_box |-> d2_s9 <= EPS_SQ)
		else $error("inside flag with large distance");

endmodule
`default_nettype wire

### rtl/sobb_sqrt.sv
`default_nettype none
module sobb_sqrt (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   vld_in,
	input  wire [63:0]            d2,
	input  sobb_pkg::sobb_side_t  side_in,
	output logic                  vld_out,
	output logic [31:0]           root,
	output sobb_pkg::sobb_side_t  side_out
);
	import sobb_pkg::*;

	// One root bit per stage, most significant first.
	logic        vld_s  [33];
	logic [63:0] rem_s  [33];
	logic [31:0] root_s [33];
	sobb_side_t  side_s [33];

	assign vld_s[0]  = vld_in;
	assign rem_s[0]  = d2;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < 32; g++) begin : g_stage
		localparam int B = 31 - g;
		logic [65:0] trial;
		logic        take;

		assign trial = ({34'b0, root_s[g]} << (B + 1)) + (66'd1 << (2 * B));
		assign take  = ({2'b0, rem_s[g]} >= trial);

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= take ? rem_s[g] - trial[63:0] : rem_s[g];
			root_s[g+1] <= take ? (root_s[g] | (32'd1 << B)) : root_s[g];
			side_s[g+1] <= side_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	assign vld_out  = vld_s[32];
	assign root     = root_s[32];
	assign side_out = side_s[32];

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[32] |-> {1'b0, rem_s[32]} <= {root_s[32], 1'b0})
		else $error("square root remainder too large");
	a_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[16] |-> root_s[16][15:0] == 16'd0)
		else $error("root bit resolved early");
	a_vld_flow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[31] |=> vld_s[32])
		else $error("valid lost in last stage");

endmodule
`default_nettype wire

### rtl/sobb_div.sv
`default_nettype none
module sobb_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   vld_in,
	input  wire [31:0]            root,
	input  sobb_pkg::sobb_side_t  side_in,
	output logic                  vld_out,
	output logic [2:0][sobb_pkg::QTW-1:0] quo,
	output logic [31:0]           dlen,
	output sobb_pkg::sobb_side_t  side_out
);
	import sobb_pkg::*;

	localparam int NW = 47;

	// Stage 0 forms the rounded numerators, then one quotient bit per stage.
	logic           vld_s  [QTW+1];
	logic [NW-1:0]  num_s  [QTW+1][3];
	logic [QTW-1:0] q_s    [QTW+1][3];
	logic [31:0]    den_s  [QTW+1];
	sobb_side_t     side_s [QTW+1];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			num_s[0][l] <= {1'b0, side_in.aoff[l], 14'b0} + NW'(root >> 1);
			q_s[0][l]   <= '0;
		end
		den_s[0]  <= root;
		side_s[0] <= side_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
		end
	end

	for (genvar g = 0; g < QTW; g++) begin : g_stage
		localparam int B = QTW - 1 - g;
		logic [NW-1:0] trial;

		assign trial = NW'(den_s[g]) << B;

		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				if (num_s[g][l] >= trial) begin
					num_s[g+1][l] <= num_s[g][l] - trial;
					q_s[g+1][l]   <= q_s[g][l] | (QTW'(1) << B);
				end else begin
					num_s[g+1][l] <= num_s[g][l];
					q_s[g+1][l]   <= q_s[g][l];
				end
			end
			den_s[g+1]  <= den_s[g];
			side_s[g+1] <= side_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	assign vld_out = vld_s[QTW];
	assign dlen    = den_s[QTW];
	assign side_out = side_s[QTW];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			quo[l] = q_s[QTW][l];
		end
	end

	logic contact;
	assign contact = vld_s[QTW] && !side_s[QTW].in_box && !side_s[QTW].miss;

	// An offset component never exceeds the distance, so the quotient stays at or below one.
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		contact |-> q_s[QTW][0] <= 15'd16384 && q_s[QTW][1] <= 15'd16384
			&& q_s[QTW][2] <= 15'd16384)
		else $error("normal quotient out of range");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		contact |-> num_s[QTW][0] < NW'(den_s[QTW]) && num_s[QTW][1] < NW'(den_s[QTW])
			&& num_s[QTW][2] < NW'(den_s[QTW]))
		else $error("division remainder not reduced");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		contact |-> den_s[QTW] != 32'd0)
		else $error("zero distance on contact path");

endmodule
`default_nettype wire

### rtl/sphere_obb_collision_core.sv
// Sphere versus oriented box contact test, fully pipelined.
// Stages from an accepted request to done: 9 transform and
// classification stages, 32 square root stages (one root bit each), 16 divider
// stages (a numerator stage, then one quotient bit each) and 2 normal rotation stages.
// Throughput: one request per cycle; busy is always low and done cannot be held off.
// Reset: arst_n clears all valid bits asynchronously; no result follows reset.
`default_nettype none
module sphere_obb_collision_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  sobb_pkg::sobb_req_t  req,
	output logic                 done,
	output sobb_pkg::sobb_rsp_t  rsp
);
	import sobb_pkg::*;

	logic                  f_vld;
	logic [63:0]           f_d2;
	sobb_side_t            f_side;
	logic                  s_vld;
	logic [31:0]           s_root;
	sobb_side_t            s_side;
	logic                  d_vld;
	logic [2:0][QTW-1:0]   d_quo;
	logic [31:0]           d_dist;
	sobb_side_t            d_side;

	assign busy = 1'b0;

	sobb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.vld    (f_vld),
		.d2     (f_d2),
		.side   (f_side)
	);

	sobb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (f_vld),
		.d2       (f_d2),
		.side_in  (f_side),
		.vld_out  (s_vld),
		.root     (s_root),
		.side_out (s_side)
	);

	sobb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (s_vld),
		.root     (s_root),
		.side_in  (s_side),
		.vld_out  (d_vld),
		.quo      (d_quo),
		.dlen     (d_dist),
		.side_out (d_side)
	);

	// stage 1: rotate the local normal back to world space
	logic               v_s1;
	logic signed [35:0] np_s1 [3][3];
	logic signed [34:0] dep_s1;
	sobb_side_t         side_s1;
	logic signed [15:0] nl [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nl[k] = d_side.neg[k] ? -$signed({1'b0, d_quo[k]}) : $signed({1'b0, d_quo[k]});
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				np_s1[i][k] <= $signed(d_side.mat[i][k]) * nl[k];
			end
		end
		dep_s1  <= ($signed({3'b0, d_side.r2x}) - $signed({3'b0, d_dist}) + 35'sd1) >>> 1;
		side_s1 <= d_side;
	end

	// stage 2: round, clamp and select the result
	logic               v_s2;
	sobb_rsp_t          rsp_s2;
	logic signed [37:0] nacc [3];
	logic signed [23:0] nw [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nacc[i] = (38'(np_s1[i][0]) + 38'(np_s1[i][1]) + 38'(np_s1[i][2])
				+ 38'sd8192) >>> 14;
			nw[i] = nacc[i][23:0];
		end
	end

	always_ff @(posedge clk) begin
		priority if (side_s1.miss) begin
			rsp_s2 <= '0;
		end else if (side_s1.in_box) begin
			rsp_s2 <= side_s1.irsp;
		end else begin
			rsp_s2.hit       <= 1'b1;
			rsp_s2.normal_x  <= clamp_nrm(nw[0]);
			rsp_s2.normal_y  <= clamp_nrm(nw[1]);
			rsp_s2.normal_z  <= clamp_nrm(nw[2]);
			rsp_s2.pen_depth <= sat32({{13{dep_s1[34]}}, dep_s1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= d_vld;
			v_s2 <= v_s1;
		end
	end

	assign done = v_s2;
	assign rsp  = rsp_s2;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.hit |-> rsp.normal_x == 16'sd0 && rsp.normal_y == 16'sd0
			&& rsp.normal_z == 16'sd0 && rsp.pen_depth == 32'sd0)
		else $error("miss with nonzero payload");
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.normal_x <= 16'sd16384 && rsp.normal_x >= -16'sd16384
			&& rsp.normal_y <= 16'sd16384 && rsp.normal_y >= -16'sd16384
			&& rsp.normal_z <= 16'sd16384 && rsp.normal_z >= -16'sd16384)
		else $error("normal out of range");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		d_vld |=> ##1 done)
		else $error("result dropped in output stages");

endmodule
`default_nettype wire
